### sv/cmmsu_pkg.sv
// ---------------------------------------------------------------------------
// cmmsu_pkg
// Shared types, constants and tables for the clock-model site update block.
// ---------------------------------------------------------------------------
package cmmsu_pkg;

    localparam int SIDE_BITS  = 6;
    localparam int SPIN_BITS  = 3;
    localparam int ADDR_BITS  = 2 * SIDE_BITS;
    localparam int LAT_DEPTH  = 1 << ADDR_BITS;

    // Command codes.
    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_TRIAL = 2'd1,
        CMD_READ  = 2'd2,
        CMD_RSVD  = 2'd3
    } t_cmd;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_ACCEPT = 2'd0,
        ST_REJECT = 2'd1,
        ST_SAME   = 2'd2,
        ST_DONE   = 2'd3
    } t_status;

    // Sequencer states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_RD_CTR,
        S_RD_N0,
        S_RD_N1,
        S_RD_N2,
        S_RD_N3,
        S_SUM,
        S_MUL,
        S_EXP1,
        S_EXP2,
        S_DEC,
        S_OUT
    } t_state;

    localparam logic [7:0] REG_CPL_ADDR = 8'd0;
    localparam logic signed [15:0] CPL_RESET = 16'sd4096;
    localparam logic [16:0] LOG2E_Q16 = 17'd94548;

    // cos(2*pi*d/8) in Q1.14.
    function automatic logic signed [15:0] cos_q14(input logic [SPIN_BITS-1:0] d);
        logic signed [15:0] v;
        case (d)
            3'd0:    v = 16'sd16384;
            3'd1:    v = 16'sd11585;
            3'd2:    v = 16'sd0;
            3'd3:    v = -16'sd11585;
            3'd4:    v = -16'sd16384;
            3'd5:    v = -16'sd11585;
            3'd6:    v = 16'sd0;
            default: v = 16'sd11585;
        endcase
        return v;
    endfunction

    // 2^(-i/16) in Q16, i in 0..16.
    function automatic logic [16:0] exp2_frac(input logic [4:0] i);
        logic [16:0] v;
        case (i)
            5'd0:    v = 17'd65536;
            5'd1:    v = 17'd62757;
            5'd2:    v = 17'd60097;
            5'd3:    v = 17'd57549;
            5'd4:    v = 17'd55109;
            5'd5:    v = 17'd52773;
            5'd6:    v = 17'd50535;
            5'd7:    v = 17'd48393;
            5'd8:    v = 17'd46341;
            5'd9:    v = 17'd44376;
            5'd10:   v = 17'd42495;
            5'd11:   v = 17'd40693;
            5'd12:   v = 17'd38968;
            5'd13:   v = 17'd37316;
            5'd14:   v = 17'd35734;
            5'd15:   v = 17'd34219;
            default: v = 17'd32768;
        endcase
        return v;
    endfunction

endpackage

### sv/cmmsu_lattice_ram.sv
// ---------------------------------------------------------------------------
// cmmsu_lattice_ram
// Single-port spin lattice memory with registered read data.
// ---------------------------------------------------------------------------
module cmmsu_lattice_ram
    import cmmsu_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [ADDR_BITS-1:0] i_addr,
    input  logic [SPIN_BITS-1:0] i_wdata,
    output logic [SPIN_BITS-1:0] o_rdata
);

    logic [SPIN_BITS-1:0] r_mem [LAT_DEPTH];
    logic [SPIN_BITS-1:0] r_rdata;

    // One access per cycle: write, or read with registered read data.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

### sv/clock_model_metropolis_site_update.sv
// ---------------------------------------------------------------------------
// clock_model_metropolis_site_update
// Metropolis trial, load and read on a 64x64 periodic clock-spin lattice.
// ---------------------------------------------------------------------------
// Write and read requests (the reserved code acts as a read), and trials that
// propose the current spin, give a result after the site access; other trials
// go on through four more lattice reads on the single memory port (five in
// all), a sum, a multiply, two exponent steps and a decision with write-back.
// The next request is taken only once the sequencer is idle and the last result
// has been taken. Reset sets J/T to 1.0; lattice undefined.
module clock_model_metropolis_site_update
    import cmmsu_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [1:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [1:0]           i_cmd,
    input  logic [5:0]           i_row,
    input  logic [5:0]           i_col,
    input  logic [2:0]           i_proposed_state,
    input  logic [2:0]           i_load_state,
    input  logic [15:0]          i_uniform_random,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [2:0]           o_site_state,
    output logic [1:0]           o_status
);

    t_state r_state, n_state;
    logic signed [15:0] r_cpl;
    logic [1:0]  r_cmd;
    logic [5:0]  r_row, r_col;
    logic [2:0]  r_prop, r_load, r_old;
    logic [15:0] r_rnd;
    logic signed [18:0] r_sum;
    logic signed [33:0] r_x;
    logic [23:0] r_y;
    logic [16:0] r_v;
    logic        r_xpos;
    logic        r_oval;
    logic [2:0]  r_osite;
    logic [1:0]  r_ostat;

    logic                 ram_we;
    logic [ADDR_BITS-1:0] ram_addr;
    logic [SPIN_BITS-1:0] ram_wdata, ram_rdata;

    logic        accept_in;
    logic        out_load;
    logic [2:0]  out_site;
    logic [1:0]  out_stat;
    logic signed [16:0] cos_term;
    logic [39:0] exp_prod;
    logic [16:0] dec_thr;
    logic        acc_dec;

    assign pready = 1'b1;
    assign prdata = {{16{r_cpl[15]}}, r_cpl};
    assign o_ready = (r_state == S_IDLE) && !r_oval;
    assign accept_in = i_valid && o_ready;
    assign o_valid = r_oval;
    assign o_site_state = r_osite;
    assign o_status = r_ostat;

    cmmsu_lattice_ram u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_addr (ram_addr),
        .i_wdata(ram_wdata),
        .o_rdata(ram_rdata)
    );

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cpl <= CPL_RESET;
        end else if (psel && penable && pwrite && paddr == REG_CPL_ADDR[1:0]) begin
            r_cpl <= pwdata[15:0];
        end
    end

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (accept_in) n_state = S_RD_CTR;
            S_RD_CTR: begin
                if (r_cmd == CMD_TRIAL) n_state = S_RD_N0;
                else                    n_state = S_OUT;
            end
            S_RD_N0:  n_state = (r_prop == ram_rdata) ? S_OUT : S_RD_N1;
            S_RD_N1:  n_state = S_RD_N2;
            S_RD_N2:  n_state = S_RD_N3;
            S_RD_N3:  n_state = S_SUM;
            S_SUM:    n_state = S_MUL;
            S_MUL:    n_state = S_EXP1;
            S_EXP1:   n_state = S_EXP2;
            S_EXP2:   n_state = S_DEC;
            S_DEC:    n_state = S_OUT;
            S_OUT:    n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // Memory address and write control per state.
    always_comb begin
        ram_we    = 1'b0;
        ram_wdata = r_load;
        ram_addr  = {r_row, r_col};
        unique case (r_state)
            S_RD_CTR: begin
                ram_we = (r_cmd == CMD_WRITE);
            end
            S_RD_N0:  ram_addr = {r_row - 6'd1, r_col};
            S_RD_N1:  ram_addr = {r_row + 6'd1, r_col};
            S_RD_N2:  ram_addr = {r_row, r_col - 6'd1};
            S_RD_N3:  ram_addr = {r_row, r_col + 6'd1};
            S_DEC: begin
                ram_we    = acc_dec;
                ram_wdata = r_prop;
            end
            default: ram_addr = {r_row, r_col};
        endcase
    end

    // Per-neighbor cosine difference; neighbor data is read from the registered memory output.
    assign cos_term = 17'(cos_q14(r_prop - ram_rdata)) - 17'(cos_q14(r_old - ram_rdata));

    // Scale x in Q16 by log2(e); only used when x is positive.
    assign exp_prod = 40'(r_x[32:10]) * 40'(LOG2E_Q16);

    // Threshold shift, taken as combinational input to the decision.
    assign dec_thr = (r_y[23:16] >= 8'd17) ? 17'd0 : (r_v >> r_y[20:16]);
    assign acc_dec = !r_xpos || ({1'b0, r_rnd} < dec_thr);

    // Result selection.
    always_comb begin
        out_load = 1'b0;
        out_site = r_old;
        out_stat = ST_DONE;
        unique case (r_state)
            S_RD_N0: begin
                out_load = (r_prop == ram_rdata);
                out_site = ram_rdata;
                out_stat = ST_SAME;
            end
            S_OUT: begin
                out_load = (r_cmd != CMD_TRIAL);
                out_site = (r_cmd == CMD_WRITE) ? r_load : ram_rdata;
                out_stat = ST_DONE;
            end
            S_DEC: begin
                out_load = 1'b1;
                out_site = acc_dec ? r_prop : r_old;
                out_stat = acc_dec ? ST_ACCEPT : ST_REJECT;
            end
            default: out_load = 1'b0;
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_oval  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_oval <= 1'b1;
            end else if (i_ready) begin
                r_oval <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (accept_in) begin
            r_cmd  <= i_cmd;
            r_row  <= i_row;
            r_col  <= i_col;
            r_prop <= i_proposed_state;
            r_load <= i_load_state;
            r_rnd  <= i_uniform_random;
        end
        if (out_load) begin
            r_osite <= out_site;
            r_ostat <= out_stat;
        end
        case (r_state)
            S_RD_N0: begin
                r_old <= ram_rdata;
                r_sum <= '0;
            end
            S_RD_N1, S_RD_N2, S_RD_N3, S_SUM: begin
                r_sum <= r_sum + 19'(cos_term);
            end
            S_MUL: begin
                r_x <= -(34'(r_cpl) * 34'(r_sum));
            end
            S_EXP1: begin
                r_xpos <= (r_x > 0);
                r_y    <= exp_prod[39:16];
            end
            S_EXP2: begin
                r_v <= exp2_frac({1'b0, r_y[15:12]})
                     - 17'(((exp2_frac({1'b0, r_y[15:12]})
                            - exp2_frac(5'({1'b0, r_y[15:12]}) + 5'd1))
                           * 29'(r_y[11:0])) >> 12);
            end
            default: ;
        endcase
    end

endmodule
